// ===== rtl/base64_stream_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared property forms for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Payload types, character job type, constants and the alphabet function.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int MAX_CHARS       = 4;
    localparam int CHAR_IDX_W      = $clog2(MAX_CHARS);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       stream_end;
    } char_item_t;

    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CHAR_IDX_W-1:0]     last_idx;
        logic                      final_byte;
    } char_job_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } group_phase_t;

    function automatic logic [7:0] enc6(input logic [5:0] v);
        logic [7:0] c;
        begin
            case (v) inside
                [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
                [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
                [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
                6'd62:         c = 8'h2B;
                default:       c = 8'h2F;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts raw bytes, tracks the group phase and carried bits, and turns
// each byte into a job of one to four output characters.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_item,
    input  logic       queue_full,
    output logic       push,
    output char_job_t  push_job
);

    group_phase_t phase_reg, phase_next;
    logic [3:0]   carry_reg, carry_next;
    logic [7:0]   b;
    logic         fin;

    assign b          = byte_item.data_byte;
    assign fin        = byte_item.final_byte;
    assign byte_ready = !queue_full;
    assign push       = byte_valid && byte_ready;

    always_comb
    begin
        case (phase_reg)
            PH_SECOND:
            begin
                carry_next = b[3:0];
                phase_next = PH_THIRD;
            end
            PH_THIRD:
            begin
                carry_next = 4'd0;
                phase_next = PH_FIRST;
            end
            default:
            begin
                carry_next = {2'b00, b[1:0]};
                phase_next = PH_SECOND;
            end
        endcase
        if (fin)
        begin
            carry_next = 4'd0;
            phase_next = PH_FIRST;
        end
    end

    always_comb
    begin
        push_job.chars      = {MAX_CHARS{PAD_CHAR}};
        push_job.final_byte = fin;
        case (phase_reg)
            PH_SECOND:
            begin
                push_job.chars[0] = enc6({carry_reg[1:0], b[7:4]});
                push_job.chars[1] = enc6({b[3:0], 2'b00});
                push_job.last_idx = fin ? CHAR_IDX_W'(2) : CHAR_IDX_W'(0);
            end
            PH_THIRD:
            begin
                push_job.chars[0] = enc6({carry_reg, b[7:6]});
                push_job.chars[1] = enc6(b[5:0]);
                push_job.last_idx = CHAR_IDX_W'(1);
            end
            default:
            begin
                push_job.chars[0] = enc6(b[7:2]);
                push_job.chars[1] = enc6({b[1:0], 4'b0000});
                push_job.last_idx = fin ? CHAR_IDX_W'(3) : CHAR_IDX_W'(0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            carry_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short first-in first-out store of character jobs between the front end
// and the back end.
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  char_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output char_job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    char_job_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Steps through the characters of the job at the queue head and presents
// them one per cycle from an output register while char_ready is high.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_macros.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  char_job_t  head_job,
    output logic       pop,
    output logic       char_valid,
    input  logic       char_ready,
    output char_item_t char_item
);

    logic [CHAR_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    char_item_t            out_item_reg, out_item_next;
    logic                  load;
    logic                  is_last;

    assign load    = head_valid && (!out_valid_reg || char_ready);
    assign is_last = (idx_reg == head_job.last_idx);
    assign pop     = load && is_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next           = 1'b1;
            out_item_next.out_char   = head_job.chars[idx_reg];
            out_item_next.run_end    = is_last;
            out_item_next.stream_end = is_last && head_job.final_byte;
            idx_next                 = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (char_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign char_valid = out_valid_reg;
    assign char_item  = out_item_reg;

    `B64E_ASSERT_SAME(a_stream_end_closes_run, clk, rst_n, char_valid && char_item.stream_end, char_item.run_end, "stream end without run end")
    `B64E_ASSERT_NEXT(a_pop_rewinds_index, clk, rst_n, pop, idx_reg == '0, "index not rewound after pop")
    `B64E_ASSERT_SAME(a_index_in_job, clk, rst_n, head_valid, idx_reg <= head_job.last_idx, "index beyond job length")
    `B64E_ASSERT_SAME(a_idle_index_zero, clk, rst_n, !head_valid, idx_reg == '0, "index moved without a job")

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard base64 characters with '=' padding.
// ----------------------------------------------------------------------------
// Each request carries one raw byte and a flag on the last byte of a stream.
// The front end takes a byte whenever the job queue has room and turns it
// into one or two characters (two to four on the last byte, padded when its
// group is incomplete); the back end sends them out one per cycle from an
// output register while the consumer holds char_ready high. The output
// register is the bottleneck: a full three-byte group yields four characters.
// A byte's first character passes through the job queue and then the output
// register before it is offered. The queue depth sets how far the input runs
// ahead of a stalled output.
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_item,
    output logic       char_valid,
    input  logic       char_ready,
    output char_item_t char_item
);

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      head_valid;
    char_job_t push_job;
    char_job_t head_job;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

endmodule
